FILE: rtl/core/continued_fraction_rational_approx_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the continued fraction approximator
// Clocked implication checks, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef CONTINUED_FRACTION_RATIONAL_APPROX_MACROS_SVH
`define CONTINUED_FRACTION_RATIONAL_APPROX_MACROS_SVH

// same-cycle implication
`define CFRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfra assertion failed");

// next-cycle implication
`define CFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfra assertion failed");

`endif

FILE: rtl/core/cfra_pkg.sv
// ----------------------------------------------------------------------------
// cfra_pkg
// Shared widths, codes, types and width helpers of the approximator.
// ----------------------------------------------------------------------------
`default_nettype none

package cfra_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int TERM_BITS_DEF = 31;

    localparam int TARGET_W   = 32;
    localparam int OUT_W      = 31;
    localparam int STATUS_W   = 2;
    localparam int TOL_W      = 16;
    localparam int LIM_W      = 14;
    localparam int ITER_W     = LIM_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd43;
    localparam logic [LIM_W-1:0] LIM_RESET = 14'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd1;

    localparam logic [STATUS_W-1:0] ST_WITHIN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_LOAD_MUL,
        ALU_MUL_STEP,
        ALU_LOAD_DIV,
        ALU_DIV_STEP
    } alu_op_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } alu_stat_t;

    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [LIM_W-1:0] iteration_limit;
    } cfg_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // lanes hold h2+n*h1, t*k, tol*k and the 2F+1 bit reciprocal
    function automatic int acc_width(input int f, input int t);
        return max_int(max_int(2 * t + 1, f + t + 1), max_int(2 * f + 1, t + TOL_W));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cfra_regs.sv
// ----------------------------------------------------------------------------
// cfra_regs
// Configuration registers: tolerance and iteration limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cfra_regs import cfra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOLERANCE:  cfg_next.tolerance = cfg_data[TOL_W-1:0];
                REG_ITER_LIMIT: cfg_next.iteration_limit = cfg_data[LIM_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance       <= TOL_RESET;
            cfg_reg.iteration_limit <= LIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cfra_alu.sv
// ----------------------------------------------------------------------------
// cfra_alu
// Shared two-lane shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "continued_fraction_rational_approx_macros.svh"

module cfra_alu import cfra_pkg::*;
#(
    parameter  int FRAC_BITS = FRAC_BITS_DEF,
    parameter  int TERM_BITS = TERM_BITS_DEF,
    localparam int ACC_W     = acc_width(FRAC_BITS, TERM_BITS)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire alu_op_t            op,
    input  wire logic [ACC_W-1:0]   ld_acc0,
    input  wire logic [ACC_W-1:0]   ld_acc1,
    input  wire logic [ACC_W-1:0]   ld_mc0,
    input  wire logic [ACC_W-1:0]   ld_mc1,
    input  wire logic [TERM_BITS-1:0] ld_mpl,
    output logic [ACC_W-1:0]        acc0,
    output logic [ACC_W-1:0]        acc1,
    output alu_stat_t               stat
);

    localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    logic [ACC_W-1:0]     acc0_reg, acc0_next;
    logic [ACC_W-1:0]     acc1_reg, acc1_next;
    logic [ACC_W-1:0]     mc0_reg, mc0_next;
    logic [ACC_W-1:0]     mc1_reg, mc1_next;
    logic [TERM_BITS-1:0] mpl_reg, mpl_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;

    logic [ACC_W-1:0] rem_sh;
    logic [ACC_W-1:0] rem_sub;
    logic             rem_ge;

    // partial remainder shifted, dividend is a single one at the top
    assign rem_sh  = {acc0_reg[ACC_W-2:0], (dcnt_reg == '0)};
    assign rem_ge  = (rem_sh >= mc0_reg);
    assign rem_sub = rem_sh - mc0_reg;

    assign acc0 = acc0_reg;
    assign acc1 = acc1_reg;
    assign stat.mul_done = (mpl_reg == '0);
    assign stat.div_done = (dcnt_reg == DCNT_W'(DIV_STEPS));

    always_comb
    begin
        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        mc0_next  = mc0_reg;
        mc1_next  = mc1_reg;
        mpl_next  = mpl_reg;
        dcnt_next = dcnt_reg;
        case (op)
            ALU_LOAD_MUL:
            begin
                acc0_next = ld_acc0;
                acc1_next = ld_acc1;
                mc0_next  = ld_mc0;
                mc1_next  = ld_mc1;
                mpl_next  = ld_mpl;
            end
            ALU_MUL_STEP:
            begin
                if (mpl_reg[0])
                begin
                    acc0_next = acc0_reg + mc0_reg;
                    acc1_next = acc1_reg + mc1_reg;
                end
                mc0_next = {mc0_reg[ACC_W-2:0], 1'b0};
                mc1_next = {mc1_reg[ACC_W-2:0], 1'b0};
                mpl_next = {1'b0, mpl_reg[TERM_BITS-1:1]};
            end
            ALU_LOAD_DIV:
            begin
                acc0_next = '0;
                acc1_next = '0;
                mc0_next  = ld_mc0;
                dcnt_next = '0;
            end
            ALU_DIV_STEP:
            begin
                acc0_next = rem_ge ? rem_sub : rem_sh;
                acc1_next = {acc1_reg[ACC_W-2:0], rem_ge};
                dcnt_next = dcnt_reg + 1'b1;
            end
            default:
            begin
                acc0_next = acc0_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc0_reg <= '0;
            acc1_reg <= '0;
            mc0_reg  <= '0;
            mc1_reg  <= '0;
            mpl_reg  <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            acc0_reg <= acc0_next;
            acc1_reg <= acc1_next;
            mc0_reg  <= mc0_next;
            mc1_reg  <= mc1_next;
            mpl_reg  <= mpl_next;
            dcnt_reg <= dcnt_next;
        end
    end

    // divisor is never zero, multiplier steps only on live bits
    `CFRA_ASSERT_IMPL(a_div_nonzero, clk, rst_n, op == ALU_DIV_STEP, mc0_reg != '0)
    `CFRA_ASSERT_IMPL(a_mul_live, clk, rst_n, op == ALU_MUL_STEP, mpl_reg != '0)
    `CFRA_ASSERT_NEXT(a_div_restart, clk, rst_n, op == ALU_LOAD_DIV, dcnt_reg == '0)

endmodule

`default_nettype wire

FILE: rtl/core/continued_fraction_rational_approx.sv
// ----------------------------------------------------------------------------
// continued_fraction_rational_approx
// Best rational approximation of a Q0.32 fraction by its continued fraction.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//  in      | in_valid/in_ready, target_fraction        | in
//  out     | out_valid/out_ready, numerator_out,       | out
//          | denominator_out, status                   |
//
//  One transaction in at a time; in_ready is high only while idle.
//  Each iteration: a range check on the term, the convergent pass
//  n*h1+h2 and n*k1+k2, the error pass t*k and tol*k, a compare, and
//  the reciprocal 2^(2F)/xf on the serial restoring divider, which
//  takes the largest share of the run time.
//  Reset is asynchronous, active low; config holds its reset values.
//  A finished result waits in the output register while the next
//  transaction is taken; the sequencer stalls only if it finishes again
//  before that result is read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "continued_fraction_rational_approx_macros.svh"

module continued_fraction_rational_approx import cfra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TERM_BITS = TERM_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [TARGET_W-1:0]   target_fraction,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_W-1:0]           numerator_out,
    output logic [OUT_W-1:0]           denominator_out,
    output logic [STATUS_W-1:0]        status
);

    localparam int F     = FRAC_BITS;
    localparam int T     = TERM_BITS;
    localparam int ACC_W = acc_width(F, T);
    localparam int XW    = max_int(F + 1, T + 1);   // term, padded for the range test
    localparam int EW    = max_int(T, OUT_W);       // convergent, padded for output
    localparam int PW    = F + T;                   // num*2^F and t*den

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV_CHK,
        S_CONV_MUL,
        S_ERR_MUL,
        S_ERR_CMP,
        S_DIV,
        S_WB
    } state_t;

    cfg_t cfg;

    // ALU hookup
    alu_op_t          alu_op;
    logic [ACC_W-1:0] ld_acc0, ld_acc1, ld_mc0, ld_mc1;
    logic [T-1:0]     ld_mpl;
    logic [ACC_W-1:0] acc0, acc1;
    alu_stat_t        alu_stat;

    state_t               state_reg, state_next;
    logic [F-1:0]         t_reg, t_next;
    logic [F:0]           xi_reg, xi_next;      // integer part of the running value
    logic [F-1:0]         xf_reg, xf_next;      // fraction part
    logic [T-1:0]         h1_reg, h1_next, h2_reg, h2_next;
    logic [T-1:0]         k1_reg, k1_next, k2_reg, k2_next;
    logic [ITER_W-1:0]    iters_reg, iters_next;
    logic [PW-1:0]        diff_reg, diff_next;
    logic [T-1:0]         rnum_reg, rnum_next, rden_reg, rden_next;
    logic [STATUS_W-1:0]  rst_reg, rst_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     onum_reg, onum_next, oden_reg, oden_next;
    logic [STATUS_W-1:0]  ost_reg, ost_next;

    logic [F+TARGET_W-1:0] t_wide;
    logic [F-1:0]          t_al;
    logic [XW-1:0]         xi_ext;
    logic                  n_ovf;
    logic                  conv_ovf;
    logic [PW-1:0]         a_val, b_val;
    logic                  err_ok;
    logic                  over_limit;
    logic [EW-1:0]         num_ext, den_ext;

    // target scaled by 2^(F-32), truncated for narrow F
    assign t_wide = {target_fraction, {F{1'b0}}};
    assign t_al   = t_wide[F+TARGET_W-1:TARGET_W];

    assign xi_ext   = XW'(xi_reg);
    assign n_ovf    = |xi_ext[XW-1:T];
    assign conv_ovf = (|acc0[ACC_W-1:T]) | (|acc1[ACC_W-1:T]);

    // |num*2^F - t*den| against tol*den
    assign a_val      = {h1_reg, {F{1'b0}}};
    assign b_val      = acc0[PW-1:0];
    assign err_ok     = (ACC_W'(diff_reg) <= acc1);
    assign over_limit = (iters_reg > ITER_W'(cfg.iteration_limit));

    assign num_ext = EW'(rnum_reg);
    assign den_ext = EW'(rden_reg);

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign numerator_out   = onum_reg;
    assign denominator_out = oden_reg;
    assign status          = ost_reg;

    cfra_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfra_alu #(
        .FRAC_BITS (FRAC_BITS),
        .TERM_BITS (TERM_BITS)
    ) u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (alu_op),
        .ld_acc0 (ld_acc0),
        .ld_acc1 (ld_acc1),
        .ld_mc0  (ld_mc0),
        .ld_mc1  (ld_mc1),
        .ld_mpl  (ld_mpl),
        .acc0    (acc0),
        .acc1    (acc1),
        .stat    (alu_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        xi_next        = xi_reg;
        xf_next        = xf_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        iters_next     = iters_reg;
        diff_next      = diff_reg;
        rnum_next      = rnum_reg;
        rden_next      = rden_reg;
        rst_next       = rst_reg;
        out_valid_next = out_valid_reg;
        onum_next      = onum_reg;
        oden_next      = oden_reg;
        ost_next       = ost_reg;

        alu_op  = ALU_HOLD;
        ld_acc0 = ACC_W'(h2_reg);
        ld_acc1 = ACC_W'(k2_reg);
        ld_mc0  = ACC_W'(h1_reg);
        ld_mc1  = ACC_W'(k1_reg);
        ld_mpl  = xi_ext[T-1:0];

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    t_next     = t_al;
                    xi_next    = '0;
                    xf_next    = t_al;
                    h1_next    = T'(1);
                    h2_next    = '0;
                    k1_next    = '0;
                    k2_next    = T'(1);
                    iters_next = '0;
                    state_next = S_CONV_CHK;
                end
            end
            S_CONV_CHK:
            begin
                // term out of range: keep the previous convergent
                if (n_ovf)
                begin
                    rnum_next  = h1_reg;
                    rden_next  = k1_reg;
                    rst_next   = ST_OVERFLOW;
                    state_next = S_WB;
                end
                else
                begin
                    alu_op     = ALU_LOAD_MUL;
                    state_next = S_CONV_MUL;
                end
            end
            S_CONV_MUL:
            begin
                ld_acc0 = '0;
                ld_acc1 = '0;
                ld_mc0  = ACC_W'(t_reg);
                ld_mc1  = ACC_W'(cfg.tolerance);
                ld_mpl  = acc1[T-1:0];
                if (!alu_stat.mul_done)
                begin
                    alu_op = ALU_MUL_STEP;
                end
                else if (conv_ovf)
                begin
                    rnum_next  = h1_reg;
                    rden_next  = k1_reg;
                    rst_next   = ST_OVERFLOW;
                    state_next = S_WB;
                end
                else
                begin
                    // accept new convergent, start t*k and tol*k
                    alu_op     = ALU_LOAD_MUL;
                    h2_next    = h1_reg;
                    h1_next    = acc0[T-1:0];
                    k2_next    = k1_reg;
                    k1_next    = acc1[T-1:0];
                    iters_next = iters_reg + 1'b1;
                    state_next = S_ERR_MUL;
                end
            end
            S_ERR_MUL:
            begin
                if (!alu_stat.mul_done)
                begin
                    alu_op = ALU_MUL_STEP;
                end
                else
                begin
                    diff_next  = (b_val <= a_val) ? (a_val - b_val) : (b_val - a_val);
                    state_next = S_ERR_CMP;
                end
            end
            S_ERR_CMP:
            begin
                ld_mc0    = ACC_W'(xf_reg);
                rnum_next = h1_reg;
                rden_next = k1_reg;
                if (err_ok || (xf_reg == '0))
                begin
                    rst_next   = ST_WITHIN;
                    state_next = S_WB;
                end
                else if (over_limit)
                begin
                    rst_next   = ST_LIMIT;
                    state_next = S_WB;
                end
                else
                begin
                    alu_op     = ALU_LOAD_DIV;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!alu_stat.div_done)
                begin
                    alu_op = ALU_DIV_STEP;
                end
                else
                begin
                    // quotient of 2^(2F)/xf: integer and fraction parts
                    xi_next    = acc1[2*F:F];
                    xf_next    = acc1[F-1:0];
                    state_next = S_CONV_CHK;
                end
            end
            S_WB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    onum_next      = num_ext[OUT_W-1:0];
                    oden_next      = den_ext[OUT_W-1:0];
                    ost_next       = rst_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            xi_reg        <= '0;
            xf_reg        <= '0;
            h1_reg        <= '0;
            h2_reg        <= '0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            iters_reg     <= '0;
            diff_reg      <= '0;
            rnum_reg      <= '0;
            rden_reg      <= '0;
            rst_reg       <= ST_WITHIN;
            out_valid_reg <= 1'b0;
            onum_reg      <= '0;
            oden_reg      <= '0;
            ost_reg       <= ST_WITHIN;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            xi_reg        <= xi_next;
            xf_reg        <= xf_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            k1_reg        <= k1_next;
            k2_reg        <= k2_next;
            iters_reg     <= iters_next;
            diff_reg      <= diff_next;
            rnum_reg      <= rnum_next;
            rden_reg      <= rden_next;
            rst_reg       <= rst_next;
            out_valid_reg <= out_valid_next;
            onum_reg      <= onum_next;
            oden_reg      <= oden_next;
            ost_reg       <= ost_next;
        end
    end

    `CFRA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
    `CFRA_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, (status == ST_WITHIN || status == ST_LIMIT || status == ST_OVERFLOW))
    `CFRA_ASSERT_NEXT(a_wb_delivers, clk, rst_n, (state_reg == S_WB) && (!out_valid_reg || out_ready), out_valid && in_ready)

endmodule

`default_nettype wire

FILE: bench/continued_fraction_rational_approx_tb.sv
// ----------------------------------------------------------------------------
// continued_fraction_rational_approx_tb
// Self-checking bench for the continued-fraction rational approximator.
// Fractions and register writes go out through a queue-fed driver. A
// scoreboard expands each accepted fraction in fixed point to predict
// numerator, denominator and status. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module continued_fraction_rational_approx_tb import cfra_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // widest convergent and term that still fit, and the fraction mask
    localparam logic [63:0] CONV_MAX  = (64'd1 << TERM_BITS_DEF) - 64'd1;
    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS_DEF) - 64'd1;

    // register indexes with nothing behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int ITEM_TARGET = 1250;

    typedef struct packed {
        logic [OUT_W-1:0]    numerator;
        logic [OUT_W-1:0]    denominator;
        logic [STATUS_W-1:0] status;
    } approx_t;

    // one pending transaction: a register write or a fraction
    typedef struct {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [TARGET_W-1:0]   fraction;
    } cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TARGET_W-1:0]   target_fraction = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_W-1:0]      numerator_out;
    logic [OUT_W-1:0]      denominator_out;
    logic [STATUS_W-1:0]   status;

    cmd_t    cmd_q[$];
    approx_t approx_q[$];

    // register copies seen by the scoreboard
    logic [TOL_W-1:0] tol_now   = TOL_RESET;
    logic [LIM_W-1:0] limit_now = LIM_RESET;

    int queued_items  = 0;
    int queued_writes = 0;
    int items_taken   = 0;
    int writes_taken  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int status_count[4] = '{0, 0, 0, 0};

    int   gap_left   = 0;
    int   stall_left = 0;
    logic drv_steady = 1'b0;
    logic mon_steady = 1'b0;

    continued_fraction_rational_approx i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .target_fraction (target_fraction),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .numerator_out   (numerator_out),
        .denominator_out (denominator_out),
        .status          (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------

    // next = older + term*newer; false when the term or the sum won't fit
    function automatic logic grow_convergent(input logic [63:0] older,
                                             input logic [63:0] term,
                                             input logic [63:0] newer,
                                             output logic [63:0] next_val);
        logic [127:0] sum;
        sum      = 128'(term) * 128'(newer) + 128'(older);
        next_val = sum[63:0];
        return (term <= CONV_MAX) && (sum <= 128'(CONV_MAX));
    endfunction

    // Expands the fraction term by term; x is held as an integer term plus
    // a FRAC_BITS remainder, the reciprocal is truncated.
    function automatic approx_t best_convergent(input logic [TARGET_W-1:0] target,
                                                input logic [TOL_W-1:0]    tol,
                                                input logic [LIM_W-1:0]    max_iter);
        logic [63:0]  term;
        logic [63:0]  rem;
        logic [63:0]  h_new;
        logic [63:0]  h_old;
        logic [63:0]  k_new;
        logic [63:0]  k_old;
        logic [63:0]  h_next;
        logic [63:0]  k_next;
        logic [127:0] aligned;
        logic [127:0] scaled;
        logic [127:0] err;
        logic [127:0] quot;
        int unsigned  steps;
        logic         done;
        approx_t      res;
        term   = '0;
        rem    = 64'(target);
        h_new  = 64'd1;
        h_old  = '0;
        k_new  = '0;
        k_old  = 64'd1;
        steps  = 0;
        done   = 1'b0;
        res.status = ST_LIMIT;
        while (!done)
        begin
            if (!grow_convergent(h_old, term, h_new, h_next) ||
                !grow_convergent(k_old, term, k_new, k_next))
            begin
                // keep the previous convergent
                res.status = ST_OVERFLOW;
                done = 1'b1;
            end
            else
            begin
                h_old = h_new;
                h_new = h_next;
                k_old = k_new;
                k_new = k_next;
                steps++;
                // |h*2^F - t*k| <= tol*k, all integer
                aligned = 128'(h_new) << FRAC_BITS_DEF;
                scaled  = 128'(target) * 128'(k_new);
                err     = (scaled <= aligned) ? aligned - scaled : scaled - aligned;
                if (err <= 128'(tol) * 128'(k_new) || rem == 64'd0)
                begin
                    res.status = ST_WITHIN;
                    done = 1'b1;
                end
                else if (steps > max_iter)
                begin
                    res.status = ST_LIMIT;
                    done = 1'b1;
                end
                else
                begin
                    quot = (128'd1 << (2 * FRAC_BITS_DEF)) / 128'(rem);
                    term = 64'(quot >> FRAC_BITS_DEF);
                    rem  = quot[63:0] & FRAC_MASK;
                end
            end
        end
        res.numerator   = h_new[OUT_W-1:0];
        res.denominator = k_new[OUT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pops cmd_q. Register writes wait until every expected result
    // is back, so they only land while the block is idle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic next_in_valid;
        logic next_cfg_valid;
        cmd_t cmd;
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            cfg_valid       <= 1'b0;
            target_fraction <= '0;
            cfg_index       <= '0;
            cfg_data        <= '0;
            gap_left = 0;
        end
        else
        begin
            next_in_valid  = in_valid;
            next_cfg_valid = cfg_valid;
            if (in_valid && in_ready)
            begin
                // predict with the registers as they stand now
                approx_q = {approx_q, best_convergent(target_fraction, tol_now, limit_now)};
                items_taken++;
                next_in_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOLERANCE)
                    tol_now = cfg_data[TOL_W-1:0];
                else if (cfg_index == REG_ITER_LIMIT)
                    limit_now = cfg_data[LIM_W-1:0];
                writes_taken++;
                next_cfg_valid = 1'b0;
            end
            if (!next_in_valid && !next_cfg_valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (cmd_q.size() != 0 &&
                         (!cmd_q[0].is_write || approx_q.size() == 0))
                begin
                    cmd = cmd_q.pop_front();
                    if (cmd.is_write)
                    begin
                        cfg_index      <= cmd.index;
                        cfg_data       <= cmd.data;
                        next_cfg_valid = 1'b1;
                    end
                    else
                    begin
                        target_fraction <= cmd.fraction;
                        next_in_valid   = 1'b1;
                    end
                    // wait before the following transaction; runs of no gaps too
                    if ($urandom_range(0, 39) == 0)
                        drv_steady = !drv_steady;
                    gap_left = drv_steady ? 0 : $urandom_range(0, 3);
                end
            end
            in_valid  <= next_in_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes results, checks against the oldest prediction, then
    // holds out_ready low for a random stall.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        approx_t got;
        approx_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.numerator   = numerator_out;
                got.denominator = denominator_out;
                got.status      = status;
                results_seen++;
                if (approx_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result num=%0d den=%0d status=%0d",
                                 $realtime, got.numerator, got.denominator, got.status);
                    mismatches++;
                end
                else
                begin
                    want = approx_q.pop_front();
                    status_count[want.status]++;
                    if (got.numerator !== want.numerator ||
                        got.denominator !== want.denominator ||
                        got.status !== want.status)
                    begin
                        if (mismatches < 10)
                            $display("[%0t] mismatch: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                                     $realtime, want.numerator, want.denominator, want.status,
                                     got.numerator, got.denominator, got.status);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    mon_steady = !mon_steady;
                stall_left = mon_steady ? 0 : $urandom_range(0, 3);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_fraction(input logic [TARGET_W-1:0] value);
        cmd_t cmd;
        cmd.is_write = 1'b0;
        cmd.index    = '0;
        cmd.data     = '0;
        cmd.fraction = value;
        cmd_q = {cmd_q, cmd};
        queued_items++;
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] value);
        cmd_t cmd;
        cmd.is_write = 1'b1;
        cmd.index    = index;
        cmd.data     = value;
        cmd.fraction = '0;
        cmd_q = {cmd_q, cmd};
        queued_writes++;
    endtask

    initial
    begin : stimulus
        int                    batch;
        int unsigned           den;
        int unsigned           num;
        int unsigned           shift;
        logic [63:0]           wide;
        logic [TARGET_W-1:0]   value;
        logic [CFG_DATA_W-1:0] tol_data;
        logic [CFG_DATA_W-1:0] lim_data;

        // reset values: zero, extremes, exact halves, golden ratio
        queue_fraction(32'h0000_0000);
        queue_fraction(32'hFFFF_FFFF);
        queue_fraction(32'h8000_0000);
        queue_fraction(32'h4000_0000);
        queue_fraction(32'h0000_0001);
        queue_fraction(32'h9E37_79B9);
        queue_fraction(32'h5555_5555);
        queue_fraction(32'hAAAA_AAAB);
        queue_fraction(32'h0001_0000);
        queue_fraction(32'h7FFF_FFFF);
        queue_fraction(32'hC000_0000);

        // zero tolerance, widest limit: runs end on overflow or a zero remainder
        queue_write(REG_TOLERANCE, 16'd0);
        queue_write(REG_ITER_LIMIT, 16'd16383);
        queue_fraction(32'h0000_0001);
        queue_fraction(32'hFFFF_FFFF);
        queue_fraction(32'h9E37_79B9);
        queue_fraction(32'h1234_5678);
        queue_fraction(32'h8000_0000);
        queue_fraction(32'h0000_0003);

        // limit of zero stops on the first step; widest tolerance
        queue_write(REG_ITER_LIMIT, 16'd0);
        queue_write(REG_TOLERANCE, 16'hFFFF);
        queue_fraction(32'h9E37_79B9);
        queue_fraction(32'h1234_5678);

        // limit of one with no tolerance
        queue_write(REG_ITER_LIMIT, 16'd1);
        queue_write(REG_TOLERANCE, 16'd0);
        queue_fraction(32'h9E37_79B9);
        queue_fraction(32'h5555_5555);

        // unused indexes must leave both registers alone
        queue_write(REG_SPARE_2, 16'hFFFF);
        queue_write(REG_SPARE_3, 16'h5A5A);
        queue_fraction(32'h3243_F6A8);

        // random phases: new settings, then a batch of fractions
        while (queued_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       tol_data = 16'($urandom_range(1, 15));
                1:       tol_data = 16'($urandom_range(16, 200));
                2:       tol_data = 16'($urandom);
                default: tol_data = 16'hFFFF;
            endcase
            case ($urandom_range(0, 3))
                0:       lim_data = 16'($urandom_range(0, 3));
                1:       lim_data = 16'($urandom_range(4, 40));
                2:       lim_data = {2'($urandom), 14'h3FFF};
                default: lim_data = 16'($urandom);
            endcase
            // sometimes only one register changes, in either order
            case ($urandom_range(0, 3))
                0:       queue_write(REG_TOLERANCE, tol_data);
                1:       queue_write(REG_ITER_LIMIT, lim_data);
                2:
                begin
                    queue_write(REG_ITER_LIMIT, lim_data);
                    queue_write(REG_TOLERANCE, tol_data);
                end
                default:
                begin
                    queue_write(REG_TOLERANCE, tol_data);
                    queue_write(REG_ITER_LIMIT, lim_data);
                end
            endcase
            batch = $urandom_range(40, 120);
            for (int i = 0; i < batch && queued_items < ITEM_TARGET; i++)
            begin
                case ($urandom_range(0, 7))
                    3:
                    begin
                        // near a small rational
                        den   = $urandom_range(2, 5000);
                        num   = $urandom_range(1, den - 1);
                        wide  = {32'(num), 32'd0} / 64'(den);
                        value = wide[31:0];
                    end
                    4:
                    begin
                        // few set bits: the remainder runs out early
                        shift = $urandom_range(16, 31);
                        value = $urandom & ~((32'd1 << shift) - 32'd1);
                    end
                    5:       value = 32'($urandom_range(0, 1023));
                    6:       value = 32'hFFFF_FFFF - 32'($urandom_range(0, 1023));
                    7:
                    begin
                        den   = $urandom_range(2, 300);
                        num   = $urandom_range(1, den - 1);
                        wide  = {32'(num), 32'd0} / 64'(den);
                        value = wide[31:0] + 32'($urandom_range(0, 63)) - 32'd32;
                    end
                    default: value = $urandom;
                endcase
                queue_fraction(value);
            end
        end

        // hold reset, then release it away from the rising edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything accepted and every prediction answered
        while (items_taken < queued_items || writes_taken < queued_writes ||
               approx_q.size() != 0)
            @(posedge clk);
        // room for a stray result
        repeat (300) @(posedge clk);

        $display("Ran %0d fractions under %0d register writes, %0d results checked.",
                 items_taken, writes_taken, results_seen);
        $display("Expected status mix: within %0d, limit %0d, overflow %0d; mismatches %0d.",
                 status_count[ST_WITHIN], status_count[ST_LIMIT],
                 status_count[ST_OVERFLOW], mismatches);
        if (mismatches == 0 && approx_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #700_000_000;
        $display("Timed out with %0d results still expected.", approx_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: continued_fraction_rational_approx.f
+incdir+rtl/core
rtl/core/cfra_pkg.sv
rtl/core/cfra_regs.sv
rtl/core/cfra_alu.sv
rtl/core/continued_fraction_rational_approx.sv
bench/continued_fraction_rational_approx_tb.sv
